// File: rtl/cis_pkg.sv
// ----------------------------------------------------------------------------
// cis_pkg: shared types for the camera intervalometer sequencer
// Phase, command and error codes, register indexes and the structs that move
// between the top level and the step logic.
// ----------------------------------------------------------------------------
package cis_pkg;

	// Width of the series and phase second counters.
	localparam int SECONDS_WIDTH = 32;
	// Width of the raw series length before it is clamped to the counter range.
	localparam int TOTAL_W = 34;

	typedef logic [SECONDS_WIDTH-1:0] sec_t;
	localparam sec_t SEC_MAX = '1;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_DELAY    = 3'd1,
		PH_EXPOSING = 3'd2,
		PH_INTERVAL = 3'd3,
		PH_PAUSED   = 3'd4,
		PH_STOPPED  = 3'd5,
		PH_ERROR    = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		KIND_TICK   = 3'd0,
		KIND_START  = 3'd1,
		KIND_PAUSE  = 3'd2,
		KIND_RESUME = 3'd3,
		KIND_STOP   = 3'd4,
		KIND_RESET  = 3'd5,
		KIND_LINK   = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_SETTINGS = 2'd1,
		ERR_NO_CAM   = 2'd2,
		ERR_TRIGGER  = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		CFG_DELAY    = 2'd0,
		CFG_EXPOSURE = 2'd1,
		CFG_FRAMES   = 2'd2,
		CFG_INTERVAL = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] delay;
		logic [15:0] exposure;
		logic [15:0] frames;
		logic [15:0] interval;
	} cfg_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       camera_link;
		logic       shutter_open;
		logic       trigger_ok;
	} item_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] done_frames;
		sec_t        series_seconds;
		sec_t        phase_seconds;
		sec_t        series_total;
		logic        pause_pending;
		logic        exposure_active;
		logic        camera_present;
		err_t        last_error;
	} seq_state_t;

	typedef struct packed {
		phase_t      seq_state;
		err_t        error_code;
		logic [15:0] frames_done;
		logic [15:0] frames_total;
		logic [31:0] elapsed_sec;
		logic [31:0] remaining_sec;
		logic [15:0] phase_left_sec;
		logic [15:0] phase_len_sec;
		logic        bulb_toggle;
		logic        status_changed;
	} result_t;

	function automatic logic is_running(phase_t ph);
		is_running = (ph == PH_DELAY) || (ph == PH_EXPOSING) ||
			(ph == PH_INTERVAL) || (ph == PH_PAUSED);
	endfunction

endpackage

// File: rtl/cis_if.sv
// ----------------------------------------------------------------------------
// cis_if: request channels of the camera intervalometer sequencer
// One interface for incoming event requests and one for status results, each
// with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface cis_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic       camera_link;
	logic       shutter_open;
	logic       trigger_ok;

	modport source (output valid, kind, camera_link, shutter_open, trigger_ok,
		input ready);
	modport sink (input valid, kind, camera_link, shutter_open, trigger_ok,
		output ready);
endinterface

interface cis_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  seq_state;
	logic [1:0]  error_code;
	logic [15:0] frames_done;
	logic [15:0] frames_total;
	logic [31:0] elapsed_sec;
	logic [31:0] remaining_sec;
	logic [15:0] phase_left_sec;
	logic [15:0] phase_len_sec;
	logic        bulb_toggle;
	logic        status_changed;

	modport source (output valid, seq_state, error_code, frames_done, frames_total,
		elapsed_sec, remaining_sec, phase_left_sec, phase_len_sec, bulb_toggle,
		status_changed, input ready);
	modport sink (input valid, seq_state, error_code, frames_done, frames_total,
		elapsed_sec, remaining_sec, phase_left_sec, phase_len_sec, bulb_toggle,
		status_changed, output ready);
endinterface

// File: rtl/cis_step.sv
// ----------------------------------------------------------------------------
// cis_step: next-state and status logic for one event
// Applies one tick, command or link change to the sequencer state and forms
// the status result from the updated state.
// ----------------------------------------------------------------------------
module cis_step import cis_pkg::*; (
	input  seq_state_t st,
	input  cfg_t       cfg,
	input  item_t      item,
	output seq_state_t nxt,
	output result_t    res
);

	function automatic sec_t sat_inc(sec_t v);
		sat_inc = (v == SEC_MAX) ? v : v + sec_t'(1);
	endfunction

	function automatic logic [15:0] left_of(logic [15:0] len, sec_t used);
		sec_t len_w;
		len_w = sec_t'(len);
		left_of = (used < len_w) ? 16'(len_w - used) : 16'd0;
	endfunction

	// Series length: delay + frames*(exposure+interval) - interval. Only used
	// when frames is at least one, so the subtraction cannot wrap.
	logic [16:0]        per_frame;
	logic [32:0]        frame_product;
	logic [TOTAL_W-1:0] raw_total;
	sec_t               clamped_total;

	always_comb begin
		per_frame     = 17'(cfg.exposure) + 17'(cfg.interval);
		frame_product = 33'(cfg.frames) * 33'(per_frame);
		raw_total     = TOTAL_W'(frame_product) + TOTAL_W'(cfg.delay) -
			TOTAL_W'(cfg.interval);
		clamped_total = (raw_total > TOTAL_W'(SEC_MAX)) ? SEC_MAX :
			SECONDS_WIDTH'(raw_total);
	end

	logic toggle;
	logic touched;
	logic do_open;

	always_comb begin
		nxt     = st;
		toggle  = 1'b0;
		touched = 1'b0;
		do_open = 1'b0;

		case (item.kind)
			KIND_TICK: begin
				if (st.phase == PH_DELAY || st.phase == PH_EXPOSING ||
						st.phase == PH_INTERVAL) begin
					nxt.series_seconds = sat_inc(st.series_seconds);
					nxt.phase_seconds  = sat_inc(st.phase_seconds);
					touched = 1'b1;
					if (st.phase == PH_DELAY) begin
						do_open = (nxt.series_seconds >= sec_t'(cfg.delay));
					end else if (st.phase == PH_INTERVAL) begin
						do_open = (nxt.phase_seconds >= sec_t'(cfg.interval));
					end else if (nxt.phase_seconds >= sec_t'(cfg.exposure)) begin
						if (st.exposure_active) begin
							toggle = item.shutter_open;
							nxt.exposure_active = 1'b0;
						end
						if (st.done_frames != 16'hFFFF)
							nxt.done_frames = st.done_frames + 16'd1;
						if (nxt.done_frames >= cfg.frames) begin
							nxt.phase = PH_STOPPED;
						end else if (st.pause_pending) begin
							nxt.pause_pending = 1'b0;
							nxt.phase = PH_PAUSED;
						end else begin
							nxt.phase_seconds = '0;
							nxt.phase = PH_INTERVAL;
						end
					end
				end
			end
			KIND_START: begin
				if (cfg.frames == 16'd0 || cfg.exposure == 16'd0) begin
					nxt.last_error = ERR_SETTINGS;
					nxt.phase = PH_ERROR;
				end else if (!st.camera_present) begin
					nxt.last_error = ERR_NO_CAM;
					nxt.phase = PH_ERROR;
				end else begin
					nxt.series_total   = clamped_total;
					nxt.done_frames    = '0;
					nxt.series_seconds = '0;
					nxt.phase_seconds  = '0;
					nxt.pause_pending  = 1'b0;
					nxt.phase = PH_DELAY;
				end
			end
			KIND_PAUSE: begin
				if (st.phase == PH_EXPOSING)
					nxt.pause_pending = 1'b1;
				else if (st.phase == PH_DELAY || st.phase == PH_INTERVAL)
					nxt.phase = PH_PAUSED;
			end
			KIND_RESUME: begin
				if (st.phase == PH_PAUSED) begin
					nxt.phase_seconds = '0;
					nxt.phase = PH_INTERVAL;
				end
			end
			KIND_STOP: begin
				if (is_running(st.phase)) begin
					if (st.phase == PH_EXPOSING && st.exposure_active) begin
						toggle = item.shutter_open;
						nxt.exposure_active = 1'b0;
					end
					nxt.phase = PH_STOPPED;
				end
			end
			KIND_RESET: begin
				if (st.exposure_active) begin
					toggle = item.shutter_open;
					nxt.exposure_active = 1'b0;
				end
				nxt.done_frames    = '0;
				nxt.series_seconds = '0;
				nxt.phase_seconds  = '0;
				nxt.series_total   = '0;
				nxt.last_error     = ERR_NONE;
				nxt.pause_pending  = 1'b0;
				nxt.phase = PH_IDLE;
			end
			KIND_LINK: begin
				if (st.camera_present != item.camera_link) begin
					nxt.camera_present = item.camera_link;
					touched = 1'b1;
				end
			end
			default: begin
			end
		endcase

		// Start of an exposure at the end of the delay or of an interval. A
		// shutter that is already open is adopted without a toggle.
		if (do_open) begin
			if (!st.camera_present) begin
				nxt.last_error = ERR_NO_CAM;
				nxt.phase = PH_ERROR;
			end else if (!item.shutter_open && !item.trigger_ok) begin
				nxt.last_error = ERR_TRIGGER;
				nxt.phase = PH_ERROR;
			end else begin
				toggle = !item.shutter_open;
				nxt.phase_seconds   = '0;
				nxt.exposure_active = 1'b1;
				nxt.phase = PH_EXPOSING;
			end
		end
	end

	always_comb begin
		res.seq_state      = nxt.phase;
		res.error_code     = nxt.last_error;
		res.frames_done    = nxt.done_frames;
		res.frames_total   = cfg.frames;
		res.elapsed_sec    = 32'(nxt.series_seconds);
		res.remaining_sec  = '0;
		res.phase_left_sec = '0;
		res.phase_len_sec  = '0;
		res.bulb_toggle    = toggle;
		res.status_changed = touched || (nxt.phase != st.phase);

		if (is_running(nxt.phase) && nxt.series_seconds < nxt.series_total)
			res.remaining_sec = 32'(nxt.series_total - nxt.series_seconds);

		case (nxt.phase)
			PH_DELAY: begin
				res.phase_len_sec  = cfg.delay;
				res.phase_left_sec = left_of(cfg.delay, nxt.series_seconds);
			end
			PH_EXPOSING: begin
				res.phase_len_sec  = cfg.exposure;
				res.phase_left_sec = left_of(cfg.exposure, nxt.phase_seconds);
			end
			PH_INTERVAL: begin
				res.phase_len_sec  = cfg.interval;
				res.phase_left_sec = left_of(cfg.interval, nxt.phase_seconds);
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/camera_intervalometer_sequencer.sv
// ----------------------------------------------------------------------------
// camera_intervalometer_sequencer: exposure-series sequencer for bulb mode
// Runs an initial delay, a number of bulb exposures and the gaps between them,
// driven by one-second ticks and commands, and reports status per event.
// ----------------------------------------------------------------------------
// Usage. Each request on the item channel is one event: a one-second tick, a
// start, pause, resume, stop or reset command, or a camera link change, along
// with the shutter and trigger status the camera reports at that moment.
// Every request yields exactly one result on the result channel, in order,
// carrying the sequencer state, error code, frame counts, elapsed and
// remaining series time, the current phase timing, a bulb toggle pulse and a
// status-changed flag.
// A request is captured in the input stage, evaluated by the step logic and
// written into the result register once that register is free or being taken.
// One request per cycle is accepted while results are taken; the step logic
// is a single pass, and the one multiplier (series length at start) sits inside it.
// The input stage keeps accepting while a finished result waits to be taken;
// when the result register is full and not taken, the input stage holds one
// request and then deasserts ready. No request is dropped or repeated.
// Reset clears the sequencer to idle with no camera present and loads the
// register defaults: no delay, one-second exposure, one frame, no interval.
// Register writes are taken only while the sequencer is not running.
// ----------------------------------------------------------------------------
module camera_intervalometer_sequencer import cis_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	cis_item_if.sink            item,
	cis_result_if.source        result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

	// Configuration registers.
	cfg_t cfg_q;

	// Sequencer state.
	seq_state_t st_q;

	// Input stage.
	item_t item_s1;
	logic  item_vld_s1;

	// Result register.
	result_t res_q;
	logic    res_vld_q;

	seq_state_t st_nxt;
	result_t    res_nxt;
	logic       s1_fire;
	item_t      item_in;

	// The input stage advances when the result register is empty or its
	// contents are being taken this cycle.
	assign s1_fire    = item_vld_s1 && (!res_vld_q || result.ready);
	assign item.ready = !item_vld_s1 || s1_fire;

	assign item_in.kind         = item.kind;
	assign item_in.camera_link  = item.camera_link;
	assign item_in.shutter_open = item.shutter_open;
	assign item_in.trigger_ok   = item.trigger_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay    <= 16'd0;
			cfg_q.exposure <= 16'd1;
			cfg_q.frames   <= 16'd1;
			cfg_q.interval <= 16'd0;
		end else if (cfg_we && !is_running(st_q.phase)) begin
			case (cfg_idx_t'(cfg_index))
				CFG_DELAY:    cfg_q.delay    <= cfg_data;
				CFG_EXPOSURE: cfg_q.exposure <= cfg_data;
				CFG_FRAMES:   cfg_q.frames   <= cfg_data;
				CFG_INTERVAL: cfg_q.interval <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (item.ready) begin
			item_vld_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready)
			item_s1 <= item_in;
	end

	// The step logic computes the next state and its status in one pass.
	cis_step u_step (
		.st   (st_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.phase           <= PH_IDLE;
			st_q.done_frames     <= '0;
			st_q.series_seconds  <= '0;
			st_q.phase_seconds   <= '0;
			st_q.series_total    <= '0;
			st_q.pause_pending   <= 1'b0;
			st_q.exposure_active <= 1'b0;
			st_q.camera_present  <= 1'b0;
			st_q.last_error      <= ERR_NONE;
		end else if (s1_fire) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (s1_fire) begin
			res_vld_q <= 1'b1;
		end else if (result.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire)
			res_q <= res_nxt;
	end

	assign result.valid          = res_vld_q;
	assign result.seq_state      = res_q.seq_state;
	assign result.error_code     = res_q.error_code;
	assign result.frames_done    = res_q.frames_done;
	assign result.frames_total   = res_q.frames_total;
	assign result.elapsed_sec    = res_q.elapsed_sec;
	assign result.remaining_sec  = res_q.remaining_sec;
	assign result.phase_left_sec = res_q.phase_left_sec;
	assign result.phase_len_sec  = res_q.phase_len_sec;
	assign result.bulb_toggle    = res_q.bulb_toggle;
	assign result.status_changed = res_q.status_changed;

`ifndef ASSERT_OFF
	// The sequencer state moves only when a request is evaluated.
	a_state_only_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_fire |=> $stable(st_q))
		else $error("sequencer state changed without an evaluated request");

	// Exposing always has an exposure in flight.
	a_exposing_active: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_EXPOSING |-> st_q.exposure_active)
		else $error("exposing phase without an active exposure");

	// A bulb toggle never leaves the sequencer in the initial delay.
	a_toggle_not_delay: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_q.bulb_toggle |-> res_q.seq_state != PH_DELAY)
		else $error("bulb toggle reported during initial delay");

	// Outside a running series no time is reported as left.
	a_idle_no_time_left: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && (res_q.seq_state == PH_IDLE || res_q.seq_state == PH_STOPPED ||
			res_q.seq_state == PH_ERROR)
		|-> res_q.remaining_sec == 32'd0 && res_q.phase_left_sec == 16'd0)
		else $error("time left reported outside a running series");
`endif

endmodule

// File: bench/camera_intervalometer_sequencer_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camera_intervalometer_sequencer_test: self-checking bench for the sequencer
// Sends event requests with random gaps, takes status results with random
// stalls, and checks every result against an in-bench model of the exposure
// series. Directed sequences cover the corner cases; random series and noise bursts follow.
// ----------------------------------------------------------------------------
module camera_intervalometer_sequencer_test;
	import cis_pkg::*;

	// Kind code 7 is not a command; the sequencer must ignore it.
	localparam logic [2:0] KIND_UNUSED = 3'd7;
	// Cycles without any accepted request or result before the run is abandoned.
	localparam int STALL_LIMIT = 2000;
	// Requests to send in total, directed and random.
	localparam int REQUEST_TARGET = 1380;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	cis_item_if   item_if();
	cis_result_if result_if();

	camera_intervalometer_sequencer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_if),
		.result   (result_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// Sequencer model. It mirrors the registers and the series state and is
	// advanced once for every accepted request, in order of acceptance.
	// ------------------------------------------------------------------------
	logic [15:0] cfg_delay = 16'd0;
	logic [15:0] cfg_exposure = 16'd1;
	logic [15:0] cfg_frames = 16'd1;
	logic [15:0] cfg_interval = 16'd0;

	phase_t      seq_phase = PH_IDLE;
	logic [15:0] frames_taken = '0;
	sec_t        series_elapsed = '0;
	sec_t        phase_elapsed = '0;
	sec_t        series_length = '0;
	logic        hold_after_frame = 1'b0;
	logic        bulb_held = 1'b0;
	logic        camera_seen = 1'b0;
	err_t        fault = ERR_NONE;

	// Per-request flags that the helpers below raise.
	logic status_flag;
	logic bulb_pulse;

	// Coverage tallies for the closing summary.
	int unsigned requests_seen = 0;
	int unsigned results_checked = 0;
	int unsigned series_done = 0;
	int unsigned errors_entered = 0;
	int unsigned pulses_seen = 0;
	int unsigned failures = 0;

	function automatic logic series_active();
		return seq_phase inside {PH_DELAY, PH_EXPOSING, PH_INTERVAL, PH_PAUSED};
	endfunction

	// A phase change is always reported through status_changed.
	function automatic void enter(phase_t nxt);
		if (seq_phase != nxt) begin
			seq_phase = nxt;
			status_flag = 1'b1;
			if (nxt == PH_ERROR)
				errors_entered++;
		end
	endfunction

	// The bulb line toggles, so it is pulsed only if the shutter is still open.
	function automatic void shut_bulb(logic shutter);
		if (bulb_held) begin
			if (shutter)
				bulb_pulse = 1'b1;
			bulb_held = 1'b0;
		end
	endfunction

	// An exposure needs a camera; a shutter that is already open is adopted,
	// otherwise the opening toggle must be able to succeed.
	function automatic void open_bulb(logic shutter, logic trig);
		if (!camera_seen) begin
			fault = ERR_NO_CAM;
			enter(PH_ERROR);
			return;
		end
		if (!shutter) begin
			if (!trig) begin
				fault = ERR_TRIGGER;
				enter(PH_ERROR);
				return;
			end
			bulb_pulse = 1'b1;
		end
		phase_elapsed = '0;
		bulb_held = 1'b1;
		enter(PH_EXPOSING);
	endfunction

	function automatic result_t predict_status(logic [2:0] kind, logic link, logic shutter,
			logic trig);
		result_t         r;
		longint unsigned f;
		longint unsigned total;
		logic [31:0]     len;
		logic [31:0]     used;

		status_flag = 1'b0;
		bulb_pulse = 1'b0;
		case (kind)
		KIND_TICK: begin
			// Time only runs in delay, exposing and interval.
			if (seq_phase inside {PH_DELAY, PH_EXPOSING, PH_INTERVAL}) begin
				if (series_elapsed != SEC_MAX)
					series_elapsed++;
				if (phase_elapsed != SEC_MAX)
					phase_elapsed++;
				status_flag = 1'b1;
				case (seq_phase)
				PH_DELAY: begin
					if (series_elapsed >= cfg_delay)
						open_bulb(shutter, trig);
				end
				PH_EXPOSING: begin
					if (phase_elapsed >= cfg_exposure) begin
						shut_bulb(shutter);
						if (frames_taken != 16'hFFFF)
							frames_taken++;
						if (frames_taken >= cfg_frames) begin
							enter(PH_STOPPED);
							series_done++;
						end else if (hold_after_frame) begin
							// A pause asked for during the frame takes effect now.
							hold_after_frame = 1'b0;
							enter(PH_PAUSED);
						end else begin
							phase_elapsed = '0;
							enter(PH_INTERVAL);
						end
					end
				end
				default: begin
					if (phase_elapsed >= cfg_interval)
						open_bulb(shutter, trig);
				end
				endcase
			end
		end
		KIND_START: begin
			if (cfg_frames == 16'd0 || cfg_exposure == 16'd0) begin
				fault = ERR_SETTINGS;
				enter(PH_ERROR);
			end else if (!camera_seen) begin
				fault = ERR_NO_CAM;
				enter(PH_ERROR);
			end else begin
				// Series length, clamped to the range of the second counters.
				f = 64'(cfg_frames);
				total = 64'(cfg_delay) + f * 64'(cfg_exposure) +
					(f - 64'd1) * 64'(cfg_interval);
				series_length = (total > SEC_MAX) ? SEC_MAX : sec_t'(total);
				frames_taken = '0;
				series_elapsed = '0;
				phase_elapsed = '0;
				hold_after_frame = 1'b0;
				enter(PH_DELAY);
			end
		end
		KIND_PAUSE: begin
			if (series_active() && seq_phase != PH_PAUSED) begin
				if (seq_phase == PH_EXPOSING)
					hold_after_frame = 1'b1;
				else
					enter(PH_PAUSED);
			end
		end
		KIND_RESUME: begin
			if (seq_phase == PH_PAUSED) begin
				phase_elapsed = '0;
				enter(PH_INTERVAL);
			end
		end
		KIND_STOP: begin
			if (series_active()) begin
				if (seq_phase == PH_EXPOSING)
					shut_bulb(shutter);
				enter(PH_STOPPED);
			end
		end
		KIND_RESET: begin
			shut_bulb(shutter);
			frames_taken = '0;
			series_elapsed = '0;
			phase_elapsed = '0;
			series_length = '0;
			fault = ERR_NONE;
			hold_after_frame = 1'b0;
			enter(PH_IDLE);
		end
		KIND_LINK: begin
			if (camera_seen != link) begin
				camera_seen = link;
				status_flag = 1'b1;
			end
		end
		default: ;
		endcase

		len = '0;
		used = '0;
		case (seq_phase)
		PH_DELAY: begin
			len = 32'(cfg_delay);
			used = 32'(series_elapsed);
		end
		PH_EXPOSING: begin
			len = 32'(cfg_exposure);
			used = 32'(phase_elapsed);
		end
		PH_INTERVAL: begin
			len = 32'(cfg_interval);
			used = 32'(phase_elapsed);
		end
		default: ;
		endcase

		r.seq_state = seq_phase;
		r.error_code = fault;
		r.frames_done = frames_taken;
		r.frames_total = cfg_frames;
		r.elapsed_sec = 32'(series_elapsed);
		r.remaining_sec = (series_active() && series_elapsed < series_length) ?
			32'(series_length - series_elapsed) : 32'd0;
		r.phase_left_sec = (used < len) ? 16'(len - used) : 16'd0;
		r.phase_len_sec = len[15:0];
		r.bulb_toggle = bulb_pulse;
		r.status_changed = status_flag;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Request driver. The stimulus process fills pending_requests; this block
	// presents them one at a time with a random gap before each. Inputs change
	// on the falling edge only, so the rising edge always sees settled values.
	// ------------------------------------------------------------------------
	item_t       pending_requests[$];
	result_t     expected_status[$];
	item_t       current_request = '0;
	logic        presenting = 1'b0;
	logic        req_taken = 1'b0;
	int unsigned send_gap = 0;
	int unsigned take_gap = 0;
	logic        steady = 1'b0;

	// In a steady stretch neither side idles at all.
	function automatic int unsigned draw_gap();
		return steady ? 0 : $urandom_range(0, 7);
	endfunction

	initial begin
		item_if.valid = 1'b0;
		item_if.kind = '0;
		item_if.camera_link = 1'b0;
		item_if.shutter_open = 1'b0;
		item_if.trigger_ok = 1'b0;
		result_if.ready = 1'b0;
	end

	always @(negedge clk) begin
		if (req_taken) begin
			req_taken = 1'b0;
			presenting = 1'b0;
			send_gap = draw_gap();
		end
		if (!presenting) begin
			if (send_gap > 0)
				send_gap--;
			else if (pending_requests.size() > 0) begin
				current_request = pending_requests.pop_front();
				presenting = 1'b1;
			end
		end
		// Valid is assigned once per edge, so back-to-back requests keep it high.
		item_if.valid <= presenting;
		item_if.kind <= current_request.kind;
		item_if.camera_link <= current_request.camera_link;
		item_if.shutter_open <= current_request.shutter_open;
		item_if.trigger_ok <= current_request.trigger_ok;
	end

	// On the rising edge the model takes register writes and accepted requests
	// in the order the sequencer sees them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we && !series_active()) begin
				case (cfg_idx_t'(cfg_index))
				CFG_DELAY:    cfg_delay = cfg_data;
				CFG_EXPOSURE: cfg_exposure = cfg_data;
				CFG_FRAMES:   cfg_frames = cfg_data;
				CFG_INTERVAL: cfg_interval = cfg_data;
				default: ;
				endcase
			end
			if (item_if.valid && item_if.ready) begin
				expected_status.push_back(predict_status(item_if.kind, item_if.camera_link,
					item_if.shutter_open, item_if.trigger_ok));
				req_taken = 1'b1;
				requests_seen++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result monitor. After every result taken, ready may drop for a randomly drawn
	// gap; each result is compared with the oldest expectation.
	// ------------------------------------------------------------------------
	function automatic void check_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			failures++;
		end
	endfunction

	always @(negedge clk) begin
		if (take_gap > 0) begin
			take_gap--;
			result_if.ready <= 1'b0;
		end else begin
			result_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t want;

		if (arst_n && result_if.valid && result_if.ready) begin
			take_gap = draw_gap();
			if (expected_status.size() == 0) begin
				$error("status result arrived with no request outstanding");
				failures++;
			end else begin
				want = expected_status.pop_front();
				results_checked++;
				if (result_if.bulb_toggle)
					pulses_seen++;
				check_field("seq_state", 64'(want.seq_state), 64'(result_if.seq_state));
				check_field("error_code", 64'(want.error_code), 64'(result_if.error_code));
				check_field("frames_done", 64'(want.frames_done),
					64'(result_if.frames_done));
				check_field("frames_total", 64'(want.frames_total),
					64'(result_if.frames_total));
				check_field("elapsed_sec", 64'(want.elapsed_sec),
					64'(result_if.elapsed_sec));
				check_field("remaining_sec", 64'(want.remaining_sec),
					64'(result_if.remaining_sec));
				check_field("phase_left_sec", 64'(want.phase_left_sec),
					64'(result_if.phase_left_sec));
				check_field("phase_len_sec", 64'(want.phase_len_sec),
					64'(result_if.phase_len_sec));
				check_field("bulb_toggle", 64'(want.bulb_toggle),
					64'(result_if.bulb_toggle));
				check_field("status_changed", 64'(want.status_changed),
					64'(result_if.status_changed));
			end
		end
	end

	// Watchdog: a run that stops moving is a failure, not a hang.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("no request or result moved for %0d cycles", STALL_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus. The registers as the generator last wrote them are kept in
	// plan_* so that a series gets about enough ticks to run to its end.
	// ------------------------------------------------------------------------
	int unsigned plan_delay = 0;
	int unsigned plan_exposure = 1;
	int unsigned plan_frames = 1;
	int unsigned plan_interval = 0;
	int unsigned requests_queued = 0;

	task automatic queue_request(logic [2:0] kind, logic link, logic shutter, logic trig);
		item_t it;

		it.kind = kind;
		it.camera_link = link;
		it.shutter_open = shutter;
		it.trigger_ok = trig;
		pending_requests.push_back(it);
		requests_queued++;
	endtask

	// Shutter status is random; the trigger usually works.
	task automatic queue_event(logic [2:0] kind);
		queue_request(kind, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			$urandom_range(0, 9) != 0);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
		CFG_DELAY:    plan_delay = 32'(value);
		CFG_EXPOSURE: plan_exposure = 32'(value);
		CFG_FRAMES:   plan_frames = 32'(value);
		CFG_INTERVAL: plan_interval = 32'(value);
		default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Hold the sender until everything queued has been answered, then let
	// the pipeline idle before touching the registers.
	task automatic drain();
		do
			@(posedge clk);
		while (pending_requests.size() > 0 || presenting || expected_status.size() > 0);
		repeat (4) @(posedge clk);
	endtask

	// Mostly small values so series finish quickly; sometimes any value, or
	// one of the extremes.
	function automatic logic [15:0] pick_value(int unsigned lo, int unsigned hi);
		case ($urandom_range(0, 19))
		0:       return 16'hFFFF;
		1:       return 16'h0000;
		2, 3:    return 16'($urandom_range(0, 65535));
		default: return 16'($urandom_range(lo, hi));
		endcase
	endfunction

	// A well-formed series: camera up, start, then ticks with the odd command
	// mixed in. Pauses are mostly followed by a resume a few ticks later.
	task automatic queue_series();
		longint unsigned span;
		int unsigned     ticks;
		int unsigned     roll;

		span = longint'(plan_delay) + longint'(plan_frames) * plan_exposure +
			(plan_frames > 0 ? longint'(plan_frames - 1) * plan_interval : 0);
		ticks = (span > 56) ? 60 : int'(span) + $urandom_range(0, 4);
		queue_request(KIND_LINK, 1'b1, 1'($urandom_range(0, 1)), 1'b1);
		queue_event(KIND_START);
		repeat (ticks) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				queue_event(KIND_PAUSE);
				repeat ($urandom_range(0, 3))
					queue_event(KIND_TICK);
				if ($urandom_range(0, 9) != 0)
					queue_event(KIND_RESUME);
			end else if (roll < 8) begin
				queue_request(KIND_LINK, $urandom_range(0, 3) != 0,
					1'($urandom_range(0, 1)), 1'b1);
			end else if (roll == 8) begin
				queue_event(KIND_STOP);
			end else if (roll == 9) begin
				queue_event(KIND_START);
			end else if (roll == 10) begin
				queue_event(KIND_UNUSED);
			end else if (roll == 11) begin
				queue_event(KIND_RESET);
			end else if (roll == 12) begin
				queue_event(KIND_RESUME);
			end else begin
				queue_event(KIND_TICK);
			end
		end
	endtask

	initial begin
		int unsigned phases;

		phases = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opener: one second delay, two second frames, three frames,
		// one second gaps. All four registers are written here.
		write_reg(CFG_DELAY, 16'd1);
		write_reg(CFG_EXPOSURE, 16'd2);
		write_reg(CFG_FRAMES, 16'd3);
		write_reg(CFG_INTERVAL, 16'd1);
		queue_request(KIND_TICK, 1'b0, 1'b0, 1'b1);     // tick while idle does nothing
		queue_request(KIND_START, 1'b0, 1'b0, 1'b1);    // no camera yet
		queue_request(KIND_UNUSED, 1'b1, 1'b1, 1'b1);   // unknown kind is ignored
		queue_request(KIND_LINK, 1'b1, 1'b0, 1'b1);
		queue_request(KIND_START, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_TICK, 1'b0, 1'b0, 1'b0);     // opening toggle would fail
		queue_request(KIND_RESET, 1'b0, 1'b1, 1'b1);
		queue_request(KIND_START, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_TICK, 1'b0, 1'b1, 1'b0);     // shutter already open is adopted
		queue_request(KIND_PAUSE, 1'b0, 1'b1, 1'b1);    // deferred to end of frame
		queue_request(KIND_TICK, 1'b0, 1'b1, 1'b1);
		queue_request(KIND_TICK, 1'b0, 1'b1, 1'b1);     // frame ends, pause taken
		queue_request(KIND_TICK, 1'b0, 1'b0, 1'b1);     // time is frozen while paused
		queue_request(KIND_RESUME, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_TICK, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_RESET, 1'b0, 1'b1, 1'b1);    // reset closes an open exposure
		queue_request(KIND_START, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_LINK, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_TICK, 1'b0, 1'b0, 1'b1);     // camera lost at exposure start
		queue_request(KIND_LINK, 1'b1, 1'b0, 1'b1);
		queue_request(KIND_START, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_PAUSE, 1'b0, 1'b0, 1'b1);    // pause in delay is immediate
		queue_request(KIND_STOP, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_STOP, 1'b0, 1'b0, 1'b1);     // nothing left to stop
		drain();

		// Settings that cannot make a series.
		write_reg(CFG_EXPOSURE, 16'd0);
		queue_request(KIND_START, 1'b0, 1'b0, 1'b1);
		drain();
		write_reg(CFG_EXPOSURE, 16'd1);
		write_reg(CFG_FRAMES, 16'd0);
		queue_request(KIND_START, 1'b0, 1'b0, 1'b1);
		drain();

		// Everything at its maximum: the series length saturates. The write
		// made while the series runs must not take effect.
		write_reg(CFG_DELAY, 16'hFFFF);
		write_reg(CFG_EXPOSURE, 16'hFFFF);
		write_reg(CFG_FRAMES, 16'hFFFF);
		write_reg(CFG_INTERVAL, 16'hFFFF);
		queue_request(KIND_START, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_TICK, 1'b0, 1'b0, 1'b1);
		drain();
		write_reg(CFG_DELAY, 16'd0);
		queue_request(KIND_TICK, 1'b0, 1'b0, 1'b1);
		queue_request(KIND_STOP, 1'b0, 1'b0, 1'b1);
		drain();

		// Random phases. Each ends with the sender held until every result is
		// in, which is also when the registers may change.
		while (requests_queued < REQUEST_TARGET) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0) begin
				// Usually return to idle first so the writes take effect.
				if ($urandom_range(0, 4) != 0) begin
					queue_event(KIND_RESET);
					drain();
				end
				if ($urandom_range(0, 1))
					write_reg(CFG_DELAY, pick_value(0, 3));
				if ($urandom_range(0, 1))
					write_reg(CFG_EXPOSURE, pick_value(1, 4));
				if ($urandom_range(0, 1))
					write_reg(CFG_FRAMES, pick_value(1, 5));
				if ($urandom_range(0, 1))
					write_reg(CFG_INTERVAL, pick_value(0, 3));
			end
			if ($urandom_range(0, 9) == 0) begin
				// Noise: any kind with any flags.
				repeat ($urandom_range(5, 20))
					queue_request(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end else begin
				queue_series();
			end
			drain();
			phases++;
		end
		steady = 1'b0;

		drain();
		repeat (10) @(posedge clk);
		if (expected_status.size() != 0) begin
			$error("%0d status results never arrived", expected_status.size());
			failures++;
		end

		$display("Run covered %0d random phases: %0d requests, %0d results checked.",
			phases, requests_seen, results_checked);
		$display("Series completed: %0d, error entries: %0d, bulb toggles: %0d.",
			series_done, errors_entered, pulses_seen);
		if (failures == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: filelist.f
rtl/cis_pkg.sv
rtl/cis_if.sv
rtl/cis_step.sv
rtl/camera_intervalometer_sequencer.sv
bench/camera_intervalometer_sequencer_test.sv
